### hw/rtl/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types and codes of the cursor linked list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cll_pkg;

   typedef enum logic [3:0] {
      K_PREPEND    = 4'd0,
      K_APPEND     = 4'd1,
      K_INS_BEFORE = 4'd2,
      K_INS_AFTER  = 4'd3,
      K_DEL_FRONT  = 4'd4,
      K_DEL_BACK   = 4'd5,
      K_DEL_CURSOR = 4'd6,
      K_SET        = 4'd7,
      K_MV_FRONT   = 4'd8,
      K_MV_BACK    = 4'd9,
      K_MV_PREV    = 4'd10,
      K_MV_NEXT    = 4'd11,
      K_CLEAR      = 4'd12
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NO_CURSOR = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_FIN  = 5'b00100,
      S_DONE = 5'b01000,
      S_HOLD = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      WSEL_NONE  = 2'd0,
      WSEL_FRONT = 2'd1,
      WSEL_BACK  = 2'd2,
      WSEL_CUR   = 2'd3
   } wsel_type;

   localparam int KIND_W  = 4;
   localparam int VALUE_W = 32;
   localparam int RSP_W   = 112;

endpackage

`default_nettype wire

### hw/rtl/cll_ram.sv
// ----------------------------------------------------------------------------
// cll_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
`default_nettype none

module cll_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/cursor_linked_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine
// Bounded doubly linked list of signed words with a cursor.
// ----------------------------------------------------------------------------
// Requests enter on req_*: req_tuser carries the operation, req_tdata the
// data word. Each request yields exactly one response on rsp_* with a status
// code, the list length, the cursor index (-1 when undefined) and the front,
// back and cursor words.
// One request is in flight at a time. The response is registered, and the
// next request can be accepted once the response register is loaded. The
// accept cycle reads the cursor/end node links and the free stack, S_EXEC
// rewrites links in the node memories, S_FIN does the second link write and
// reads a new front, back or cursor word, and S_DONE loads the response
// register, waiting while an earlier response is held. Clear passes through
// the same states: it resets the pool.
// The response register lets the next request be accepted while a response
// waits; a stalled receiver holds the block only once a second response is
// ready. Reset empties the list and the pool; node memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_linked_list_engine #(
   parameter int CAPACITY   = 64,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // value[31:0]
   input  wire logic [3:0]   req_tuser,   // kind[3:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], list_length[8:2], cursor_position[15:9], front_value[47:16],
   // back_value[79:48], cursor_value[111:80]
   output logic [111:0]      rsp_tdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + 1;

   cll_pkg::state_type  state_ff, state_in;
   cll_pkg::kind_type   kind_ff, kind_in;
   cll_pkg::status_type stat_ff, stat_in;
   cll_pkg::wsel_type   wsel_ff, wsel_in;
   logic [31:0]         val_ff, val_in;

   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [CW-1:0] cnt_ff, cnt_in, fs_ff, fs_in, fresh_ff, fresh_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [WORD_WIDTH-1:0] front_ff, front_in, back_ff, back_in, curw_ff, curw_in;

   logic          la_we_ff, la_we_in, lb_we_ff, lb_we_in;
   logic [IW-1:0] la_addr_ff, la_addr_in, la_data_ff, la_data_in;
   logic [IW-1:0] lb_addr_ff, lb_addr_in, lb_data_ff, lb_data_in;

   logic                     ov_ff, ov_in;
   logic [111:0]             out_ff, out_in;

   logic                  w_we, a_we, b_we, f_we;
   logic [IW-1:0]         w_wa, w_ra, a_wa, a_ra, b_wa, b_ra, f_wa, f_ra;
   logic [WORD_WIDTH-1:0] w_wd, w_rd;
   logic [IW-1:0]         a_wd, a_rd, b_wd, b_rd, f_wd, f_rd;

   logic                  req_fire, load_out;
   logic [IW-1:0]         alloc_n;
   logic [PW-1:0]         pos_last;
   logic                  pos_def;
   cll_pkg::kind_type     req_kind;

   cll_ram #(.DATA_W(WORD_WIDTH), .DEPTH(CAPACITY)) u_word (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_addr(w_ra), .rd_data(w_rd));
   cll_ram #(.DATA_W(IW), .DEPTH(CAPACITY)) u_after (
      .clock(clock), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd),
      .rd_addr(a_ra), .rd_data(a_rd));
   cll_ram #(.DATA_W(IW), .DEPTH(CAPACITY)) u_before (
      .clock(clock), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   cll_ram #(.DATA_W(IW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd));

   assign req_tready = (state_ff == cll_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = cll_pkg::kind_type'(req_tuser);
   assign alloc_n    = (fs_ff != '0) ? f_rd : fresh_ff[IW-1:0];
   assign pos_def    = !pos_ff[PW-1];
   assign pos_last   = {1'b0, cnt_ff - CW'(1)};
   assign load_out   = (state_ff == cll_pkg::S_DONE) && (!ov_ff || rsp_tready);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      logic do_alloc, do_push, drop_f, drop_b, ins_f, ins_b;
      logic [IW-1:0] push_n;
      logic [WORD_WIDTH-1:0] v;
      logic need_list, need_cur, is_ins;

      state_in   = state_ff;
      kind_in    = kind_ff;
      stat_in    = stat_ff;
      val_in     = val_ff;
      wsel_in    = wsel_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cur_in     = cur_ff;
      cnt_in     = cnt_ff;
      pos_in     = pos_ff;
      fs_in      = fs_ff;
      fresh_in   = fresh_ff;
      front_in   = front_ff;
      back_in    = back_ff;
      curw_in    = curw_ff;
      la_we_in   = 1'b0;
      la_addr_in = la_addr_ff;
      la_data_in = la_data_ff;
      lb_we_in   = 1'b0;
      lb_addr_in = lb_addr_ff;
      lb_data_in = lb_data_ff;
      ov_in      = ov_ff;
      out_in     = out_ff;

      w_we = 1'b0;  w_wa = alloc_n;  w_wd = '0;  w_ra = '0;
      a_we = 1'b0;  a_wa = '0;       a_wd = '0;
      b_we = 1'b0;  b_wa = '0;       b_wd = '0;
      f_we = 1'b0;  f_wa = fs_ff[IW-1:0];  f_wd = '0;
      a_ra = (req_kind == cll_pkg::K_DEL_FRONT) ? head_ff : cur_ff;
      b_ra = (req_kind == cll_pkg::K_DEL_BACK) ? tail_ff : cur_ff;
      f_ra = IW'(fs_ff - CW'(1));

      do_alloc  = 1'b0;
      do_push   = 1'b0;
      drop_f    = 1'b0;
      drop_b    = 1'b0;
      ins_f     = 1'b0;
      ins_b     = 1'b0;
      push_n    = '0;
      v         = WORD_WIDTH'(val_ff);
      need_list = 1'b0;
      need_cur  = 1'b0;
      is_ins    = 1'b0;

      if (rsp_tready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         cll_pkg::S_IDLE: begin
            if (req_fire) begin
               kind_in = req_kind;
               val_in  = req_tdata;
               wsel_in = cll_pkg::WSEL_NONE;
               need_list = (req_kind inside {[cll_pkg::K_INS_BEFORE:cll_pkg::K_SET]});
               need_cur  = (req_kind inside {cll_pkg::K_INS_BEFORE, cll_pkg::K_INS_AFTER,
                                             cll_pkg::K_DEL_CURSOR, cll_pkg::K_SET});
               is_ins    = (req_kind inside {[cll_pkg::K_PREPEND:cll_pkg::K_INS_AFTER]});
               if (need_list && cnt_ff == '0) begin
                  stat_in = cll_pkg::ST_EMPTY;
               end else if (need_cur && !pos_def) begin
                  stat_in = cll_pkg::ST_NO_CURSOR;
               end else if (is_ins && cnt_ff == CW'(CAPACITY)) begin
                  stat_in = cll_pkg::ST_FULL;
               end else begin
                  stat_in = cll_pkg::ST_OK;
               end
               state_in = cll_pkg::S_EXEC;
            end
         end
         cll_pkg::S_EXEC: begin
            if (stat_ff == cll_pkg::ST_OK) begin
               case (kind_ff)
                  cll_pkg::K_PREPEND:    ins_f = 1'b1;
                  cll_pkg::K_APPEND:     ins_b = 1'b1;
                  cll_pkg::K_INS_BEFORE: begin
                     if (cur_ff == head_ff) begin
                        ins_f = 1'b1;
                     end else begin
                        do_alloc   = 1'b1;
                        b_we = 1'b1;  b_wa = alloc_n;  b_wd = b_rd;
                        a_we = 1'b1;  a_wa = b_rd;     a_wd = alloc_n;
                        la_we_in = 1'b1;  la_addr_in = alloc_n;  la_data_in = cur_ff;
                        lb_we_in = 1'b1;  lb_addr_in = cur_ff;   lb_data_in = alloc_n;
                        cnt_in = cnt_ff + CW'(1);
                        pos_in = pos_ff + PW'(1);
                     end
                  end
                  cll_pkg::K_INS_AFTER: begin
                     if (cur_ff == tail_ff) begin
                        ins_b = 1'b1;
                     end else begin
                        do_alloc   = 1'b1;
                        a_we = 1'b1;  a_wa = alloc_n;  a_wd = a_rd;
                        b_we = 1'b1;  b_wa = a_rd;     b_wd = alloc_n;
                        lb_we_in = 1'b1;  lb_addr_in = alloc_n;  lb_data_in = cur_ff;
                        la_we_in = 1'b1;  la_addr_in = cur_ff;   la_data_in = alloc_n;
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  cll_pkg::K_DEL_FRONT: drop_f = 1'b1;
                  cll_pkg::K_DEL_BACK:  drop_b = 1'b1;
                  cll_pkg::K_DEL_CURSOR: begin
                     if (pos_ff == '0) begin
                        drop_f = 1'b1;
                     end else if (pos_ff == pos_last) begin
                        drop_b = 1'b1;
                     end else begin
                        b_we = 1'b1;  b_wa = a_rd;  b_wd = b_rd;
                        a_we = 1'b1;  a_wa = b_rd;  a_wd = a_rd;
                        do_push = 1'b1;
                        push_n  = cur_ff;
                        cnt_in  = cnt_ff - CW'(1);
                        pos_in  = '1;
                        cur_in  = '0;
                     end
                  end
                  cll_pkg::K_SET: begin
                     w_we = 1'b1;  w_wa = cur_ff;  w_wd = v;
                     curw_in = v;
                     if (cur_ff == head_ff) begin
                        front_in = v;
                     end
                     if (cur_ff == tail_ff) begin
                        back_in = v;
                     end
                  end
                  cll_pkg::K_MV_FRONT: begin
                     if (cnt_ff != '0) begin
                        cur_in  = head_ff;
                        pos_in  = '0;
                        curw_in = front_ff;
                     end
                  end
                  cll_pkg::K_MV_BACK: begin
                     if (cnt_ff != '0) begin
                        cur_in  = tail_ff;
                        pos_in  = pos_last;
                        curw_in = back_ff;
                     end
                  end
                  cll_pkg::K_MV_PREV: begin
                     if (pos_def) begin
                        if (cur_ff == head_ff) begin
                           cur_in = '0;
                           pos_in = '1;
                        end else begin
                           cur_in  = b_rd;
                           pos_in  = pos_ff - PW'(1);
                           w_ra    = b_rd;
                           wsel_in = cll_pkg::WSEL_CUR;
                        end
                     end
                  end
                  cll_pkg::K_MV_NEXT: begin
                     if (pos_def) begin
                        if (cur_ff == tail_ff) begin
                           cur_in = '0;
                           pos_in = '1;
                        end else begin
                           cur_in  = a_rd;
                           pos_in  = pos_ff + PW'(1);
                           w_ra    = a_rd;
                           wsel_in = cll_pkg::WSEL_CUR;
                        end
                     end
                  end
                  cll_pkg::K_CLEAR: begin
                     cnt_in   = '0;
                     pos_in   = '1;
                     fs_in    = '0;
                     fresh_in = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     cur_in   = '0;
                  end
                  default: ;
               endcase

               if (ins_f) begin
                  do_alloc = 1'b1;
                  if (cnt_ff == '0) begin
                     tail_in = alloc_n;
                     back_in = v;
                  end else begin
                     a_we = 1'b1;  a_wa = alloc_n;  a_wd = head_ff;
                     b_we = 1'b1;  b_wa = head_ff;  b_wd = alloc_n;
                  end
                  head_in  = alloc_n;
                  front_in = v;
                  cnt_in   = cnt_ff + CW'(1);
                  if (pos_def) begin
                     pos_in = pos_ff + PW'(1);
                  end
               end
               if (ins_b) begin
                  do_alloc = 1'b1;
                  if (cnt_ff == '0) begin
                     head_in  = alloc_n;
                     front_in = v;
                  end else begin
                     b_we = 1'b1;  b_wa = alloc_n;  b_wd = tail_ff;
                     a_we = 1'b1;  a_wa = tail_ff;  a_wd = alloc_n;
                  end
                  tail_in = alloc_n;
                  back_in = v;
                  cnt_in  = cnt_ff + CW'(1);
               end
               if (drop_f) begin
                  do_push = 1'b1;
                  push_n  = head_ff;
                  cnt_in  = cnt_ff - CW'(1);
                  if (cnt_ff == CW'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = a_rd;
                     w_ra    = a_rd;
                     wsel_in = cll_pkg::WSEL_FRONT;
                  end
                  if (pos_def) begin
                     pos_in = pos_ff - PW'(1);
                     if (pos_ff == '0) begin
                        cur_in = '0;
                     end
                  end
               end
               if (drop_b) begin
                  do_push = 1'b1;
                  push_n  = tail_ff;
                  cnt_in  = cnt_ff - CW'(1);
                  if (cnt_ff == CW'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     tail_in = b_rd;
                     w_ra    = b_rd;
                     wsel_in = cll_pkg::WSEL_BACK;
                  end
                  if (pos_ff == pos_last) begin
                     pos_in = '1;
                     cur_in = '0;
                  end
               end
               if (do_alloc) begin
                  w_we = 1'b1;  w_wa = alloc_n;  w_wd = v;
                  if (fs_ff != '0) begin
                     fs_in = fs_ff - CW'(1);
                  end else begin
                     fresh_in = fresh_ff + CW'(1);
                  end
               end
               if (do_push) begin
                  f_we  = 1'b1;
                  f_wd  = push_n;
                  fs_in = fs_ff + CW'(1);
               end
            end
            state_in = cll_pkg::S_FIN;
         end
         cll_pkg::S_FIN: begin
            a_we = la_we_ff;  a_wa = la_addr_ff;  a_wd = la_data_ff;
            b_we = lb_we_ff;  b_wa = lb_addr_ff;  b_wd = lb_data_ff;
            case (wsel_ff)
               cll_pkg::WSEL_FRONT: front_in = w_rd;
               cll_pkg::WSEL_BACK:  back_in  = w_rd;
               cll_pkg::WSEL_CUR:   curw_in  = w_rd;
               default: ;
            endcase
            state_in = cll_pkg::S_DONE;
         end
         cll_pkg::S_DONE: begin
            if (load_out) begin
               ov_in = 1'b1;
               out_in[1:0]    = stat_ff;
               out_in[8:2]    = 7'(cnt_ff);
               out_in[15:9]   = 7'($signed(pos_ff));
               out_in[47:16]  = (cnt_ff != '0) ? 32'($signed(front_ff)) : '0;
               out_in[79:48]  = (cnt_ff != '0) ? 32'($signed(back_ff)) : '0;
               out_in[111:80] = (pos_def && cnt_ff != '0) ? 32'($signed(curw_ff)) : '0;
               state_in = cll_pkg::S_IDLE;
            end
         end
         default: state_in = cll_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cll_pkg::S_IDLE;
         wsel_ff  <= cll_pkg::WSEL_NONE;
         head_ff  <= '0;
         tail_ff  <= '0;
         cur_ff   <= '0;
         cnt_ff   <= '0;
         pos_ff   <= '1;
         fs_ff    <= '0;
         fresh_ff <= '0;
         la_we_ff <= 1'b0;
         lb_we_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wsel_ff  <= wsel_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cur_ff   <= cur_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         fs_ff    <= fs_in;
         fresh_ff <= fresh_in;
         la_we_ff <= la_we_in;
         lb_we_ff <= lb_we_in;
         ov_ff    <= ov_in;
      end
      kind_ff    <= kind_in;
      stat_ff    <= stat_in;
      val_ff     <= val_in;
      front_ff   <= front_in;
      back_ff    <= back_in;
      curw_ff    <= curw_in;
      la_addr_ff <= la_addr_in;
      la_data_ff <= la_data_in;
      lb_addr_ff <= lb_addr_in;
      lb_data_ff <= lb_data_in;
      out_ff     <= out_in;
   end

   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (CW'(cnt_ff + fs_ff) == fresh_ff))
      else $error("live plus free nodes differ from used nodes");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CW'(CAPACITY)))
      else $error("list length beyond capacity");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      (pos_def |-> (pos_ff[PW-2:0] < cnt_ff)))
      else $error("cursor index beyond list length");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_fire |=> !req_tready ##1 !req_tready))
      else $error("request accepted while another is in flight");

endmodule

`default_nettype wire

### dv/cll_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cll_checker
// Watches the request and response streams of the cursor linked list engine,
// keeps its own copy of the list, predicts each response and compares it.
// ----------------------------------------------------------------------------
`default_nettype none

module cll_checker
   import cll_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [31:0]  req_tdata,
   input  wire logic [3:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [111:0] rsp_tdata,
   output int                fail_count,
   output int                pending
);

   localparam int CAP = 64;

   typedef struct packed {
      logic [31:0] cursor_value;
      logic [31:0] back_value;
      logic [31:0] front_value;
      logic [6:0]  cursor_position;
      logic [6:0]  list_length;
      logic [1:0]  status;
   } list_view_t;

   // the list as an array of words, front first
   logic [31:0] list_words [$];
   int          cur_idx;
   list_view_t  expected_views [$];

   assign pending = expected_views.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic list_view_t apply_request(input kind_type kind,
                                                input logic [31:0] value);
      list_view_t v;
      int n;
      status_type st;
      logic need_list, need_cur, is_ins;
      n = list_words.size();
      need_list = kind inside {K_INS_BEFORE, K_INS_AFTER, K_DEL_FRONT, K_DEL_BACK,
                               K_DEL_CURSOR, K_SET};
      need_cur = kind inside {K_INS_BEFORE, K_INS_AFTER, K_DEL_CURSOR, K_SET};
      is_ins = kind inside {K_PREPEND, K_APPEND, K_INS_BEFORE, K_INS_AFTER};
      st = ST_OK;
      if (need_list && n == 0) st = ST_EMPTY;
      else if (need_cur && cur_idx < 0) st = ST_NO_CURSOR;
      else if (is_ins && n == CAP) st = ST_FULL;
      if (st == ST_OK) begin
         case (kind)
            K_PREPEND: begin
               list_words.push_front(value);
               if (cur_idx >= 0) cur_idx++;
            end
            K_APPEND: list_words.push_back(value);
            K_INS_BEFORE: begin
               list_words.insert(cur_idx, value);
               cur_idx++;
            end
            K_INS_AFTER: list_words.insert(cur_idx + 1, value);
            K_DEL_FRONT: begin
               void'(list_words.pop_front());
               if (cur_idx >= 0) cur_idx--;
            end
            K_DEL_BACK: begin
               void'(list_words.pop_back());
               if (cur_idx == list_words.size()) cur_idx = -1;
            end
            K_DEL_CURSOR: begin
               list_words.delete(cur_idx);
               cur_idx = -1;
            end
            K_SET: list_words[cur_idx] = value;
            K_MV_FRONT: if (n > 0) cur_idx = 0;
            K_MV_BACK: if (n > 0) cur_idx = n - 1;
            K_MV_PREV: if (cur_idx >= 0) cur_idx--;
            K_MV_NEXT: if (cur_idx >= 0) cur_idx = (cur_idx == n - 1) ? -1 : cur_idx + 1;
            K_CLEAR: begin
               list_words.delete();
               cur_idx = -1;
            end
            default: ;
         endcase
      end
      n = list_words.size();
      v.status = st;
      v.list_length = 7'(n);
      v.cursor_position = 7'(cur_idx);
      v.front_value = n > 0 ? list_words[0] : '0;
      v.back_value = n > 0 ? list_words[n-1] : '0;
      v.cursor_value = (cur_idx >= 0 && n > 0) ? list_words[cur_idx] : '0;
      return v;
   endfunction

   always @(posedge clock) begin
      list_view_t got, want;
      if (reset) begin
         list_words.delete();
         cur_idx = -1;
         expected_views.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_views.size() == 0) begin
               report_mismatch("unexpected response", 32'(got.status), 32'd0);
            end else begin
               want = expected_views.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 32'(got.status), 32'(want.status));
               if (got.list_length !== want.list_length)
                  report_mismatch("list_length", 32'(got.list_length),
                                  32'(want.list_length));
               if (got.cursor_position !== want.cursor_position)
                  report_mismatch("cursor_position", 32'(got.cursor_position),
                                  32'(want.cursor_position));
               if (got.front_value !== want.front_value)
                  report_mismatch("front_value", got.front_value, want.front_value);
               if (got.back_value !== want.back_value)
                  report_mismatch("back_value", got.back_value, want.back_value);
               if (got.cursor_value !== want.cursor_value)
                  report_mismatch("cursor_value", got.cursor_value, want.cursor_value);
            end
         end
         if (req_tvalid && req_tready)
            expected_views.push_back(apply_request(kind_type'(req_tuser), req_tdata));
      end
   end

endmodule

`default_nettype wire

### dv/tb_cursor_linked_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_linked_list_engine
// Drives list operations with random gaps and receiver stalls; a checker
// module beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cursor_linked_list_engine;
   import cll_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;   // value[31:0]
   logic [3:0]   req_tuser;   // kind[3:0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   // status[1:0], list_length[8:2], cursor_position[15:9], front_value[47:16],
   // back_value[79:48], cursor_value[111:80]
   logic [111:0] rsp_tdata;
   int           fail_count;
   int           pending;
   int           idle_cycles;
   logic         hold_rsp;

   cursor_linked_list_engine DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   cll_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input kind_type kind, input logic [31:0] value);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tuser <= kind;
      req_tdata <= value;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // phase 0 skews toward inserts, phase 1 toward deletes, phase 2 is not skewed
   function automatic kind_type random_kind(input int phase);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return kind_type'($urandom_range(13, 15));
      if (r < 4) return K_CLEAR;
      if (phase == 0 && r < 60) return kind_type'($urandom_range(0, 3));
      if (phase == 1 && r < 50) return kind_type'($urandom_range(4, 6));
      return kind_type'($urandom_range(0, 11));
   endfunction

   initial begin
      rsp_tready = 1'b0;
      hold_rsp = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (gap_length() + 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty-list preconditions, then ends, cursor moves and a full pool
      send_request(K_DEL_FRONT, 0);
      send_request(K_DEL_BACK, 0);
      send_request(K_DEL_CURSOR, 0);
      send_request(K_SET, 1);
      send_request(K_INS_BEFORE, 2);
      send_request(K_INS_AFTER, 3);
      send_request(K_MV_NEXT, 0);
      send_request(K_MV_FRONT, 0);
      send_request(K_CLEAR, 0);
      send_request(K_APPEND, 32'h7fff_ffff);
      send_request(K_SET, 5);
      send_request(K_PREPEND, 32'h8000_0000);
      send_request(K_MV_FRONT, 0);
      send_request(K_INS_BEFORE, 32'hffff_ffff);
      send_request(K_INS_AFTER, 32'h0);
      send_request(K_SET, 32'h5555_aaaa);
      send_request(K_MV_PREV, 0);
      send_request(K_MV_PREV, 0);
      send_request(K_MV_BACK, 0);
      send_request(K_MV_NEXT, 0);
      send_request(kind_type'(4'd15), 0);
      for (int i = 0; i < 66; i++) send_request(K_APPEND, random_word());
      send_request(K_MV_BACK, 0);
      send_request(K_DEL_CURSOR, 0);
      send_request(K_CLEAR, 0);

      for (int i = 0; i < 460; i++) begin
         if (i == 150) hold_rsp = 1'b1;
         send_request(random_kind((i / 90) % 3), random_word());
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hw/rtl/cll_pkg.sv
hw/rtl/cll_ram.sv
hw/rtl/cursor_linked_list_engine.sv
dv/cll_checker.sv
dv/tb_cursor_linked_list_engine.sv
